// ===== hw/rtl/mtp_pkg.sv =====
// Shared constants, command and status types, and tempering for the MT19937 unit.
package mtp_pkg;

    localparam int unsigned MT_WORDS  = 624;
    localparam int unsigned MT_SHIFT  = 397;
    localparam int unsigned ADDR_W    = $clog2(MT_WORDS);

    localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
    localparam logic [31:0] MT_UPPER     = 32'h8000_0000;
    localparam logic [31:0] MT_LOWER     = 32'h7FFF_FFFF;
    localparam logic [31:0] MT_MATRIX    = 32'h9908_B0DF;
    localparam logic [31:0] MT_TEMPER_B  = 32'h9D2C_5680;
    localparam logic [31:0] MT_TEMPER_C  = 32'hEFC6_0000;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MT_WORDS - 1);
    localparam logic [ADDR_W-1:0] WRAP_ADDR = ADDR_W'(MT_WORDS - MT_SHIFT);
    localparam logic [ADDR_W-1:0] FAR_STEP  = ADDR_W'(MT_SHIFT);

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef struct packed {
        logic seed_load;
        logic seed_mul;
        logic seed_add;
        logic rd_pair;
        logic rd_far;
        logic twist;
    } mtp_cmd_t;

    typedef struct packed {
        logic seed_last;
        logic out_blocked;
    } mtp_sts_t;

    function automatic logic [31:0] temper(input logic [31:0] y_in);
        logic [31:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== hw/rtl/mtp_ctrl.sv =====
// Sequencer for seeding and drawing in the MT19937 unit.
module mtp_ctrl
    import mtp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     opcode,
    output logic     in_stall,
    input  mtp_sts_t sts,
    output mtp_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SEED_MUL = 6'b000010,
        ST_SEED_ADD = 6'b000100,
        ST_RD_FAR   = 6'b001000,
        ST_TWIST    = 6'b010000,
        ST_SPARE    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_SEED)
                    begin
                        cmd.seed_load = 1'b1;
                        state_next    = ST_SEED_MUL;
                    end
                    else
                    begin
                        cmd.rd_pair = 1'b1;
                        state_next  = ST_RD_FAR;
                    end
                end
            end
            ST_SEED_MUL:
            begin
                cmd.seed_mul = 1'b1;
                state_next   = ST_SEED_ADD;
            end
            ST_SEED_ADD:
            begin
                cmd.seed_add = 1'b1;
                state_next   = sts.seed_last ? ST_IDLE : ST_SEED_MUL;
            end
            ST_RD_FAR:
            begin
                cmd.rd_far = 1'b1;
                state_next = ST_TWIST;
            end
            ST_TWIST:
            begin
                if (!sts.out_blocked)
                begin
                    cmd.twist  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/mtp_dpath.sv =====
// Word store, seeding arithmetic, twist, tempering and output register of the MT19937 unit.
module mtp_dpath
    import mtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mtp_cmd_t    cmd,
    output mtp_sts_t    sts,
    input  logic [31:0] seed_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] random_value
);

    logic [31:0] mem [MT_WORDS];

    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              seeded_reg, seeded_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg, out_data_next;
    logic [31:0]       prev_reg, prev_next;
    logic [31:0]       prod_reg, prod_next;
    logic [31:0]       y_reg, y_next;
    logic [31:0]       rd_a_reg, rd_b_reg;

    logic [ADDR_W-1:0] next_addr, far_addr, addr_b, wr_addr;
    logic [31:0]       wr_data, mix, seed_word, twist_word;
    logic              wr_en;

    assign next_addr = (pos_reg == LAST_ADDR) ? '0 : pos_reg + 1'b1;
    assign far_addr  = (pos_reg >= WRAP_ADDR) ? pos_reg - WRAP_ADDR : pos_reg + FAR_STEP;
    assign addr_b    = cmd.rd_pair ? next_addr : far_addr;

    assign mix        = prev_reg ^ (prev_reg >> 30);
    assign prod_next  = MT_INIT_MULT * mix;
    assign seed_word  = prod_reg + {{(32 - ADDR_W){1'b0}}, idx_reg};
    assign y_next     = (rd_a_reg & MT_UPPER) | (rd_b_reg & MT_LOWER);
    assign twist_word = seeded_reg
                      ? (rd_b_reg ^ (y_reg >> 1) ^ (y_reg[0] ? MT_MATRIX : 32'd0))
                      : 32'd0;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = twist_word;
        if (cmd.seed_load)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = seed_value;
        end
        else if (cmd.seed_add)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg;
            wr_data = seed_word;
        end
        else if (cmd.twist)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        seeded_next    = seeded_reg;
        prev_next      = prev_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.seed_load)
        begin
            prev_next = seed_value;
            idx_next  = ADDR_W'(1);
        end
        if (cmd.seed_add)
        begin
            prev_next = seed_word;
            idx_next  = idx_reg + 1'b1;
            if (idx_reg == LAST_ADDR)
            begin
                seeded_next = 1'b1;
                pos_next    = '0;
            end
        end
        if (cmd.twist)
        begin
            pos_next       = next_addr;
            out_data_next  = temper(twist_word);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_pair)
        begin
            rd_a_reg <= mem[pos_reg];
        end
        if (cmd.rd_pair || cmd.rd_far)
        begin
            rd_b_reg <= mem[addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        out_data_reg <= out_data_next;
        if (cmd.seed_mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.rd_far)
        begin
            y_reg <= y_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            idx_reg       <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.seed_last   = (idx_reg == LAST_ADDR);
    assign sts.out_blocked = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign random_value    = out_data_reg;

endmodule

// ===== hw/rtl/mersenne_twister_prng_unit.sv =====
// Top level of the MT19937 unit: sequencer, datapath and checks.
//
//   channel  dir  handshake             fields
//   in       in   in_valid / in_stall   opcode, seed_value
//   out      out  out_valid / out_stall random_value
//
// A draw beat reaches the result register in steps (pair read at
// acceptance, far read, then twist and write); the input stalls until the draw is done.
// A seed beat writes word 0 at acceptance, then one multiply and one add/write per further word.
// A draw waits in its last step while a previous result is stalled at the output.
// Reset clears control only; until the first seed every draw returns zero.
module mersenne_twister_prng_unit
    import mtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] seed_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] random_value
);

    mtp_cmd_t cmd;
    mtp_sts_t sts;

    mtp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    mtp_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value)
    );

`ifndef SYNTHESIS
    a_seed_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && opcode == OP_SEED && !out_valid) |=> !out_valid)
        else $error("seed beat produced a result");

    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while idle");

    a_draw_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
        else $error("result appeared one cycle after acceptance");
`endif

endmodule

// ===== tb/mersenne_twister_prng_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the MT19937 unit: queued seed and draw beats checked against a local predictor.
module mersenne_twister_prng_unit_test;
    import mtp_pkg::*;

    localparam int unsigned RUN_LIMIT    = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 1400;
    localparam int unsigned RANDOM_BEATS = 1550;
    localparam int unsigned LONG_RUN     = 720;

    typedef struct {
        logic        op;
        logic [31:0] seed;
        int unsigned gap;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = OP_SEED;
    logic [31:0] seed_value = 32'h0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] random_value;

    beat_t       stim_beats[$];
    beat_t       cur_beat;
    logic [31:0] expected_draws[$];
    logic [31:0] exp_word;
    logic [31:0] mt_words[MT_WORDS];
    int unsigned mt_pos = 0;

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned feed_gap = 0;
    int unsigned stall_left = 0;
    int unsigned drawn_count = 0;
    int unsigned queued_count = 0;
    bit          feed_calm = 1'b0;
    bit          out_calm = 1'b0;

    mersenne_twister_prng_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned draw_wait(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    task automatic seed_fill(input logic [31:0] s);
        logic [31:0] prev;
        mt_words[0] = s;
        for (int unsigned i = 1; i < MT_WORDS; i++)
        begin
            prev = mt_words[i - 1];
            mt_words[i] = MT_INIT_MULT * (prev ^ (prev >> 30)) + 32'(i);
        end
        mt_pos = 0;
    endtask

    task automatic twist_and_temper(output logic [31:0] tempered);
        int unsigned nxt;
        int unsigned far_idx;
        logic [31:0] mix;
        logic [31:0] w;
        nxt = (mt_pos + 1) % MT_WORDS;
        far_idx = (mt_pos + MT_SHIFT) % MT_WORDS;
        mix = (mt_words[mt_pos] & MT_UPPER) | (mt_words[nxt] & MT_LOWER);
        w = mt_words[far_idx] ^ (mix >> 1);
        if (mix[0])
            w = w ^ MT_MATRIX;
        mt_words[mt_pos] = w;
        mt_pos = nxt;
        w = w ^ (w >> 11);
        w = w ^ ((w << 7) & MT_TEMPER_B);
        w = w ^ ((w << 15) & MT_TEMPER_C);
        tempered = w ^ (w >> 18);
    endtask

    task automatic predict_beat(input logic op, input logic [31:0] s);
        logic [31:0] t;
        if (op == OP_SEED)
            seed_fill(s);
        else
        begin
            twist_and_temper(t);
            expected_draws.push_back(t);
        end
    endtask

    task automatic add_beat(input logic op, input logic [31:0] s);
        beat_t b;
        if (queued_count % 40 == 0)
            feed_calm = ($urandom_range(0, 2) == 0);
        b.op = op;
        b.seed = s;
        b.gap = draw_wait(feed_calm);
        stim_beats.push_back(b);
        queued_count++;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: hold the beat while stalled, advance on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_beat(opcode, seed_value);
            if (!in_valid || !in_stall)
            begin
                if (feed_gap != 0)
                begin
                    feed_gap--;
                    in_valid <= 1'b0;
                end
                else if (stim_beats.size() != 0)
                begin
                    cur_beat = stim_beats.pop_front();
                    opcode <= cur_beat.op;
                    seed_value <= cur_beat.seed;
                    in_valid <= 1'b1;
                    feed_gap = (stim_beats.size() != 0) ? stim_beats[0].gap : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result beat, then draw the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_draws.size() == 0)
                begin
                    $display("%0t: random_value expected none, got %h", $time, random_value);
                    fail_count++;
                end
                else
                begin
                    exp_word = expected_draws.pop_front();
                    if (exp_word !== random_value)
                    begin
                        $display("%0t: random_value expected %h, got %h",
                                 $time, exp_word, random_value);
                        fail_count++;
                    end
                end
                drawn_count++;
                if (drawn_count % 40 == 0)
                    out_calm = ($urandom_range(0, 2) == 0);
                stall_left = draw_wait(out_calm);
                out_stall <= (stall_left != 0);
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= (stall_left != 0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] pick;
        for (int unsigned i = 0; i < MT_WORDS; i++)
            mt_words[i] = 32'h0;

        // draws before any seed return zero
        add_beat(OP_DRAW, 32'hFFFF_FFFF);
        add_beat(OP_DRAW, 32'h0);
        add_beat(OP_DRAW, 32'h1234_5678);
        add_beat(OP_SEED, 32'h0);
        add_beat(OP_DRAW, 32'h0);
        add_beat(OP_DRAW, 32'hFFFF_FFFF);
        add_beat(OP_SEED, 32'hFFFF_FFFF);
        add_beat(OP_DRAW, 32'hFFFF_FFFF);
        add_beat(OP_DRAW, 32'h0);
        add_beat(OP_SEED, 32'h1);
        add_beat(OP_SEED, 32'h8000_0000);
        add_beat(OP_DRAW, 32'h0);
        add_beat(OP_SEED, 32'd5489);
        add_beat(OP_DRAW, 32'h0);
        add_beat(OP_DRAW, 32'h0);
        add_beat(OP_DRAW, 32'h0);
        add_beat(OP_SEED, 32'h7FFF_FFFF);
        add_beat(OP_DRAW, 32'h8000_0000);
        add_beat(OP_SEED, 32'hAAAA_AAAA);
        add_beat(OP_DRAW, 32'h5555_5555);
        add_beat(OP_SEED, 32'h5555_5555);
        add_beat(OP_DRAW, 32'hAAAA_AAAA);

        // long run past the wrap of the store
        add_beat(OP_SEED, $urandom);
        repeat (LONG_RUN) add_beat(OP_DRAW, $urandom);

        while (queued_count < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                case ($urandom_range(0, 7))
                    0: pick = 32'h0;
                    1: pick = 32'hFFFF_FFFF;
                    default: pick = $urandom;
                endcase
                add_beat(OP_SEED, pick);
            end
            else
                add_beat(OP_DRAW, $urandom);
        end

        wait (rst_n);
        while (stim_beats.size() != 0 || in_valid || expected_draws.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_draws.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
